[rtl/assert_macros.svh]
// assertion macros used by the top-level filter
// no dependencies; compiled out when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define BMF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// expression must never be true outside reset
`define BMF_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("forbidden condition");
`else
`define BMF_ASSERT(lbl, clk, rst, prop)
`define BMF_NEVER(lbl, clk, rst, expr)
`endif
`endif

[rtl/bmf_pkg.sv]
// package for the box mean filter: payload types, register codes, defaults
// no dependencies
`timescale 1ns / 1ps
package bmf_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd3;

  // boundary modes
  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;
  localparam logic [1:0] MODE_ADJUST = 2'd2;

  localparam logic [11:0] RST_WIDTH  = 12'd512;
  localparam logic [11:0] RST_HEIGHT = 12'd512;
  localparam logic [2:0]  RST_RADIUS = 3'd3;
  localparam logic [1:0]  RST_MODE   = MODE_MIRROR;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_in;
  } bmf_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } bmf_out_t;

endpackage

[rtl/box_mean_filter_boundary_modes_top.sv]
// sequence: a request that releases a pixel walks up to 2r+1 window rows of 2r+1 columns each,
// then runs the divider on the sum before the result is loaded into the output register
// flow: one request at a time; in_stall is high whenever the sequencer is out of idle, so the
// next request waits until the last one is through, including any output stall
// reset: synchronous, clears counters and flags, sets config defaults; line buffer is not cleared
`timescale 1ns / 1ps
module box_mean_filter_boundary_modes_top #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bmf_pkg::bmf_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bmf_pkg::bmf_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmf_pkg::CFG_W-1:0]      cfg_data
);
  import bmf_pkg::*;
`include "assert_macros.svh"

  // geometry widths
  localparam int BR    = 2 * MAX_RADIUS + 1;        // rows held in the line buffer
  localparam int BKW   = $clog2(BR);
  localparam int DEPTH = BR * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT);
  localparam int W1    = $clog2(MAX_WIDTH + 1);
  localparam int H1    = $clog2(MAX_HEIGHT + 1);
  localparam int GW    = (W1 > H1) ? W1 : H1;
  localparam int SW    = ((GW > CFG_W) ? GW : CFG_W) + 2;  // signed coordinate width
  localparam int SUM_W = $clog2(BR * BR * 255 + 1);
  localparam int CNT_W = $clog2(BR * BR + 1);

  // row modulo BR by reciprocal multiplication, exact for every HW-bit row index
  localparam int MK      = HW + BKW;
  localparam int MOD_MUL = (2 ** MK + BR - 1) / BR;
  localparam int MUL_W   = HW + MK + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_ROWSET = 3'd2;
  localparam logic [2:0] S_ROWMOD = 3'd3;
  localparam logic [2:0] S_COL    = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;

  // configuration registers
  logic [CFG_W-1:0] cfg_w, cfg_h;
  logic [2:0]       cfg_r;
  logic [1:0]       cfg_mode;

  // raster counters
  logic [CW-1:0]  in_col, out_col;
  logic [HW-1:0]  in_row, out_row;
  logic [BKW-1:0] in_bank;
  logic           pending;

  // window walk
  logic signed [SW-1:0] a_off, b_off;
  logic [HW-1:0]        mod_val;
  logic [BKW-1:0]       mod_rem;
  logic                 rd_pend;
  logic [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]     cnt;

  logic                 out_last;

  // effective geometry
  logic signed [SW-1:0] w_eff, h_eff, r_eff, side, rr;

  always_comb begin
    w_eff = SW'(cfg_w);
    if (w_eff == 0) w_eff = SW'(1);
    if (w_eff > SW'(MAX_WIDTH)) w_eff = SW'(MAX_WIDTH);
    h_eff = SW'(cfg_h);
    if (h_eff == 0) h_eff = SW'(1);
    if (h_eff > SW'(MAX_HEIGHT)) h_eff = SW'(MAX_HEIGHT);
    r_eff = SW'(cfg_r);
    if (r_eff > SW'(MAX_RADIUS)) r_eff = SW'(MAX_RADIUS);
    if (cfg_mode == MODE_MIRROR) begin
      rr = ((w_eff < h_eff) ? w_eff : h_eff) - SW'(1);
      if (r_eff > rr) r_eff = rr;
    end else begin
      rr = '0;
    end
    side = (r_eff <<< 1) + SW'(1);
  end

  // reflection about the edge pixel, edge not repeated
  function automatic logic signed [SW-1:0] reflect(input logic signed [SW-1:0] k,
                                                   input logic signed [SW-1:0] n);
    logic signed [SW-1:0] v;
    v = k;
    if (v < 0) v = -v;
    if (v > n - SW'(1)) v = ((n - SW'(1)) <<< 1) - v;
    if (v < 0) v = '0;
    if (v > n - SW'(1)) v = n - SW'(1);
    return v;
  endfunction

  // counters as they stand after a geometry change
  logic signed [SW-1:0] ic_c, ir_c, oc_c, or_c;
  logic [BKW-1:0]       ib_c;

  always_comb begin
    ic_c = (SW'(in_col)  >= w_eff) ? '0 : SW'(in_col);
    ir_c = (SW'(in_row)  >= h_eff) ? '0 : SW'(in_row);
    ib_c = (SW'(in_row)  >= h_eff) ? '0 : in_bank;
    oc_c = (SW'(out_col) >= w_eff) ? '0 : SW'(out_col);
    or_c = (SW'(out_row) >= h_eff) ? '0 : SW'(out_row);
  end

  // line buffer access
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  logic          in_take;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign ram_we    = in_take && (in_data.req_type == REQ_PIXEL);
  assign ram_waddr = AW'(ib_c) * AW'(MAX_WIDTH) + AW'(ic_c);

  // column fetch for the current window row
  logic signed [SW-1:0] xs, ys, xr, yr;
  logic                 x_ok, y_ok;

  always_comb begin
    xs = SW'(out_col) + b_off;
    ys = SW'(out_row) + a_off;
    if (cfg_mode == MODE_MIRROR) begin
      xr   = reflect(xs, w_eff);
      yr   = reflect(ys, h_eff);
      x_ok = 1'b1;
      y_ok = 1'b1;
    end else begin
      xr   = xs;
      yr   = ys;
      x_ok = (xs >= 0) && (xs < w_eff);
      y_ok = (ys >= 0) && (ys < h_eff);
    end
  end

  assign ram_re    = (state == S_COL) && x_ok;
  assign ram_raddr = AW'(mod_rem) * AW'(MAX_WIDTH) + AW'(xr[CW-1:0]);

  bmf_ram #(.DATA_W(8), .DEPTH(DEPTH)) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.pixel_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // mean divider
  logic             div_start, div_busy, div_done;
  logic [SUM_W-1:0] div_quot;
  logic [CNT_W-1:0] div_den;

  assign div_den = (cfg_mode == MODE_ADJUST) ? cnt : CNT_W'(side * side);

  bmf_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // next output position in the raster
  logic signed [SW-1:0] nr, nc;
  logic                 out_ready_now;

  always_comb begin
    nr = SW'(out_row) + r_eff;
    if (nr > h_eff - SW'(1)) nr = h_eff - SW'(1);
    nc = SW'(out_col) + r_eff;
    if (nc > w_eff - SW'(1)) nc = w_eff - SW'(1);
    // input position past the last pixel the window needs
    out_ready_now = pending || (SW'(in_row) > nr) ||
                    ((SW'(in_row) == nr) && (SW'(in_col) > nc));
  end

  // bank of a window row
  logic [MUL_W-1:0] mod_prod;
  logic [HW-1:0]    mod_quo;
  logic [HW-1:0]    mod_diff;

  assign mod_prod = MUL_W'(mod_val) * MUL_W'(MOD_MUL);
  assign mod_quo  = mod_prod[MK +: HW];
  assign mod_diff = mod_val - mod_quo * HW'(BR);

  logic signed [SW-1:0] ic_n, ir_n, oc_n, or_n;
  logic                 out_load;

  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign div_start = (state == S_TAIL) && !rd_pend && (a_off == r_eff) && !div_busy;

  always_comb begin
    ic_n = ic_c + SW'(1);
    ir_n = ir_c + SW'(1);
    oc_n = SW'(out_col) + SW'(1);
    or_n = SW'(out_row) + SW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg_w     <= RST_WIDTH;
      cfg_h     <= RST_HEIGHT;
      cfg_r     <= RST_RADIUS;
      cfg_mode  <= RST_MODE;
      in_col    <= '0;
      in_row    <= '0;
      in_bank   <= '0;
      out_col   <= '0;
      out_row   <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WIDTH:  cfg_w    <= cfg_data;
          REG_HEIGHT: cfg_h    <= cfg_data;
          REG_RADIUS: cfg_r    <= cfg_data[2:0];
          REG_MODE:   cfg_mode <= cfg_data[1:0];
          default: ;
        endcase
      end

      // output register: loaded from the sequencer, emptied when taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            // restart counters beyond a changed frame size
            out_col <= oc_c[CW-1:0];
            out_row <= or_c[HW-1:0];
            if (in_data.req_type == REQ_PIXEL) begin
              if (ic_n >= w_eff) begin
                in_col <= '0;
                if (ir_n >= h_eff) begin
                  in_row  <= '0;
                  in_bank <= '0;
                  pending <= 1'b1;
                end else begin
                  in_row  <= ir_n[HW-1:0];
                  in_bank <= (ib_c == BKW'(BR - 1)) ? '0 : ib_c + 1'b1;
                end
              end else begin
                in_col  <= ic_n[CW-1:0];
                in_row  <= ir_c[HW-1:0];
                in_bank <= ib_c;
              end
            end else begin
              in_col  <= ic_c[CW-1:0];
              in_row  <= ir_c[HW-1:0];
              in_bank <= ib_c;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (out_ready_now) begin
            a_off <= -r_eff;
            sum   <= '0;
            cnt   <= '0;
            state <= S_ROWSET;
          end else begin
            state <= S_IDLE;
          end
        end
        S_ROWSET: begin
          if (y_ok) begin
            // bank of the window row: row index modulo the number of buffered rows
            mod_val <= yr[HW-1:0];
            state   <= S_ROWMOD;
          end else if (a_off == r_eff) begin
            rd_pend <= 1'b0;
            state   <= S_TAIL;
          end else begin
            a_off <= a_off + SW'(1);
          end
        end
        S_ROWMOD: begin
          mod_rem <= mod_diff[BKW-1:0];
          b_off   <= -r_eff;
          rd_pend <= 1'b0;
          state   <= S_COL;
        end
        S_COL: begin
          if (rd_pend) begin
            sum <= sum + SUM_W'(ram_rdata);
            cnt <= cnt + 1'b1;
          end
          rd_pend <= x_ok;
          if (b_off == r_eff) begin
            state <= S_TAIL;
          end else begin
            b_off <= b_off + SW'(1);
          end
        end
        S_TAIL: begin
          if (rd_pend) begin
            sum     <= sum + SUM_W'(ram_rdata);
            cnt     <= cnt + 1'b1;
            rd_pend <= 1'b0;
          end else if (a_off == r_eff) begin
            if (div_start) begin
              state <= S_DIV;
            end
          end else begin
            a_off <= a_off + SW'(1);
            state <= S_ROWSET;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data.pixel_out <= (div_den == '0) ? 8'd0 : div_quot[7:0];
            out_data.frame_end <= out_last;
            if (oc_n >= w_eff) begin
              out_col <= '0;
              if (or_n >= h_eff) begin
                out_row <= '0;
                pending <= 1'b0;
              end else begin
                out_row <= or_n[HW-1:0];
              end
            end else begin
              out_col <= oc_n[CW-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_last = (oc_n >= w_eff) && (or_n >= h_eff);

  // line buffer is never read while a request is being written
  `BMF_NEVER(a_no_rw_overlap, clk, rst, ram_we && ram_re)
  // divider is only started when idle
  `BMF_NEVER(a_div_idle_start, clk, rst, div_start && div_busy)
  // the last pixel of a frame clears the pending frame
  `BMF_ASSERT(a_frame_end_clears, clk, rst, (out_load && out_last) |=> !pending)
  // a new output never overwrites one still waiting
  `BMF_ASSERT(a_no_overwrite, clk, rst, (out_valid && out_stall) |=> out_valid)

endmodule

[rtl/bmf_ram.sv]
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
module bmf_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/bmf_div.sv]
// iterative restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module bmf_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dreg;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
        rem  <= '0;
        quot <= num;
        dreg <= den;
      end else if (busy) begin
        // shift in next dividend bit, subtract when it fits
        if (trial >= {1'b0, dreg}) begin
          rem  <= trial - {1'b0, dreg};
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
